[design/dhtc_pkg.sv]
// Shared types and constants for the debounced hold-time classifier.
package dhtc_pkg;

  localparam int unsigned CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Input beat actions
  typedef enum logic [1:0] {
    ACT_SAMPLE  = 2'd0,
    ACT_CLEAR   = 2'd1,
    ACT_RESTART = 2'd2
  } action_t;

  // Hold phase of one level
  typedef enum logic [1:0] {
    PH_NONE  = 2'd0,
    PH_SHORT = 2'd1,
    PH_MID   = 2'd2,
    PH_LONG  = 2'd3
  } phase_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_INIT_VAL     = 3'd0,
    REG_TRUE_SHORT   = 3'd1,
    REG_TRUE_LONG    = 3'd2,
    REG_FALSE_SHORT  = 3'd3,
    REG_FALSE_LONG   = 3'd4,
    REG_STABLE_TRUE  = 3'd5,
    REG_STABLE_FALSE = 3'd6
  } reg_idx_t;

  // Sticky flag bit positions; the false group sits FALSE_GRP above the true group
  localparam int unsigned FLG_WAS   = 0;
  localparam int unsigned FLG_SHORT = 1;
  localparam int unsigned FLG_LONG  = 2;
  localparam int unsigned FALSE_GRP = 3;

  // Run timer enable bits
  localparam int unsigned RUN_TRUE  = 0;
  localparam int unsigned RUN_FALSE = 1;

  typedef struct packed {
    logic             init_val;
    logic [CNT_W-1:0] true_short;
    logic [CNT_W-1:0] true_long;
    logic [CNT_W-1:0] false_short;
    logic [CNT_W-1:0] false_long;
    logic [CNT_W-1:0] stable_true;
    logic [CNT_W-1:0] stable_false;
  } cfg_t;

  typedef struct packed {
    logic             filt;
    logic [CNT_W-1:0] glitch;
    logic [CNT_W-1:0] true_run;
    logic [CNT_W-1:0] false_run;
    phase_t           true_stage;
    phase_t           false_stage;
    logic [5:0]       sticky;
    logic [1:0]       run_active;
  } state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
    sat_inc = (x == CNT_MAX) ? x : x + CNT_W'(1);
  endfunction

endpackage

[design/dhtc_core.sv]
// Next-state logic: debounce, run timers, phase classification, sticky flags.
module dhtc_core
  import dhtc_pkg::*;
(
  input  state_t     state_i,
  input  cfg_t       cfg_i,
  input  logic [1:0] action_i,
  input  logic       raw_i,
  input  logic [5:0] mask_i,
  output state_t     state_o
);

  logic             same;
  logic [CNT_W-1:0] glitch_inc;
  logic [CNT_W-1:0] need;
  logic             flip;
  logic             filt_new;
  logic [CNT_W-1:0] run_cur;
  logic [CNT_W-1:0] run_new;
  logic [CNT_W-1:0] short_t;
  logic [CNT_W-1:0] long_t;
  logic [2:0]       grp_flags;
  phase_t           ph_new;
  state_t           smp;

  // Debounce: count differing ticks, flip once the stable count is reached
  assign same       = (raw_i == state_i.filt);
  assign glitch_inc = sat_inc(state_i.glitch);
  assign need       = raw_i ? cfg_i.stable_true : cfg_i.stable_false;
  assign flip       = !same && (glitch_inc >= need);
  assign filt_new   = flip ? raw_i : state_i.filt;

  // Timer and thresholds of the level now held
  assign run_cur = filt_new ? state_i.true_run : state_i.false_run;
  assign short_t = filt_new ? cfg_i.true_short : cfg_i.false_short;
  assign long_t  = filt_new ? cfg_i.true_long : cfg_i.false_long;
  assign run_new = (filt_new ? state_i.run_active[RUN_TRUE] :
                               state_i.run_active[RUN_FALSE]) ?
                   sat_inc(run_cur) : '0;

  // Classify hold time
  always_comb begin
    grp_flags = 3'b001;
    if (run_new < short_t) begin
      ph_new = PH_SHORT;
    end else if (run_new < long_t) begin
      ph_new = PH_MID;
      grp_flags[FLG_SHORT] = 1'b1;
    end else begin
      ph_new = PH_LONG;
      grp_flags[FLG_LONG] = 1'b1;
    end
  end

  // State after a sample beat
  always_comb begin
    smp        = state_i;
    smp.filt   = filt_new;
    smp.glitch = (same || flip) ? '0 : glitch_inc;
    if (filt_new) begin
      smp.false_run             = '0;
      smp.false_stage           = PH_NONE;
      smp.run_active[RUN_FALSE] = 1'b0;
      smp.run_active[RUN_TRUE]  = 1'b1;
      smp.true_run              = run_new;
      smp.true_stage            = ph_new;
      smp.sticky                = state_i.sticky | {3'b000, grp_flags};
    end else begin
      smp.true_run              = '0;
      smp.true_stage            = PH_NONE;
      smp.run_active[RUN_TRUE]  = 1'b0;
      smp.run_active[RUN_FALSE] = 1'b1;
      smp.false_run             = run_new;
      smp.false_stage           = ph_new;
      smp.sticky                = state_i.sticky | {grp_flags, 3'b000};
    end
  end

  // Action select
  always_comb begin
    state_o = state_i;
    case (action_t'(action_i))
      ACT_SAMPLE: begin
        state_o = smp;
      end
      ACT_CLEAR: begin
        state_o.sticky = state_i.sticky & ~mask_i;
      end
      ACT_RESTART: begin
        state_o.filt       = cfg_i.init_val;
        state_o.glitch     = '0;
        state_o.true_run   = '0;
        state_o.false_run  = '0;
        state_o.run_active = 2'b00;
        state_o.sticky     = '0;
        if (cfg_i.init_val) begin
          state_o.true_stage         = PH_SHORT;
          state_o.false_stage        = PH_NONE;
          state_o.sticky[FLG_WAS]    = 1'b1;
        end else begin
          state_o.true_stage                   = PH_NONE;
          state_o.false_stage                  = PH_SHORT;
          state_o.sticky[FALSE_GRP + FLG_WAS]  = 1'b1;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

[design/debounced_hold_time_classifier.sv]
// Top level: debounced hold-time classifier with config registers and output skid.
//
// Each input beat is a sample tick, a sticky-flag clear by mask, or a restart
// (action in in_tuser). The block debounces the raw sample, times how long the
// filtered level has held (saturating 16-bit tick counts), classifies that
// time as under short, short to long, or long, and keeps six sticky flags.
// Every input beat yields exactly one result beat carrying the state after
// the action. One beat per clock is sustained while results are taken: the
// whole state update is one pass of logic from the state registers, and an
// output register backed by a one-entry skid stage keeps accepting while a
// result waits; results are registered in it or in the skid stage. Config
// writes take effect at once and are meant to be done while the block is idle.
module debounced_hold_time_classifier
  import dhtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] raw_value, [6:1] clear_mask, [7] zero
  input  logic [1:0]  in_tuser,   // [1:0] action
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [0] filtered_value, [2:1] true_phase,
                                  // [4:3] false_phase, [10:5] sticky_flags,
                                  // [26:11] true_time, [42:27] false_time,
                                  // [47:43] zero
  // config write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t        cfg_r;
  state_t      state_r;
  state_t      state_nxt;
  state_t      state_rst;
  logic [47:0] res;
  logic [47:0] out_data_r;
  logic        out_valid_r;
  logic [47:0] skid_data_r;
  logic        skid_valid_r;
  logic        in_acc;
  logic        out_free;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_INIT_VAL:     cfg_r.init_val     <= cfg_wdata[0];
        REG_TRUE_SHORT:   cfg_r.true_short   <= cfg_wdata;
        REG_TRUE_LONG:    cfg_r.true_long    <= cfg_wdata;
        REG_FALSE_SHORT:  cfg_r.false_short  <= cfg_wdata;
        REG_FALSE_LONG:   cfg_r.false_long   <= cfg_wdata;
        REG_STABLE_TRUE:  cfg_r.stable_true  <= cfg_wdata;
        REG_STABLE_FALSE: cfg_r.stable_false <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dhtc_core u_core (
    .state_i  (state_r),
    .cfg_i    (cfg_r),
    .action_i (in_tuser),
    .raw_i    (in_tdata[0]),
    .mask_i   (in_tdata[6:1]),
    .state_o  (state_nxt)
  );

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Reset value: level false, false timer in its short phase, was-false flag set
  always_comb begin
    state_rst                             = '0;
    state_rst.true_stage                  = PH_NONE;
    state_rst.false_stage                 = PH_SHORT;
    state_rst.sticky[FALSE_GRP + FLG_WAS] = 1'b1;
  end

  // Classifier state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= state_rst;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // Result packing
  assign res = {5'b00000, state_nxt.false_run, state_nxt.true_run, state_nxt.sticky,
                2'(state_nxt.false_stage), 2'(state_nxt.true_stage), state_nxt.filt};

  // Output register and skid stage, control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Output register and skid stage, data
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_acc) begin
        out_data_r <= res;
      end
    end else if (in_acc) begin
      skid_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The skid stage only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry without output entry");

  // A beat taken while the output stalls lands in the skid stage
  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && out_valid_r && !out_tready) |=> skid_valid_r)
    else $error("stalled beat lost");

  // Only the held level's timer may run
  a_true_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.filt |-> (state_r.true_run == '0 && state_r.true_stage == PH_NONE))
    else $error("true timer active while false");

  a_false_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.filt |-> (state_r.false_run == '0 && state_r.false_stage == PH_NONE))
    else $error("false timer active while true");

endmodule

[tb/tb.sv]
// Self-checking testbench for the debounced hold-time classifier.
`timescale 1ns / 1ps

module tb;
  import dhtc_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_PRINTED    = 40;
  localparam int unsigned DRAIN_CYCLES   = 4;

  // One result beat, last field in the lowest bits
  typedef struct packed {
    logic [15:0] false_time;
    logic [15:0] true_time;
    logic [5:0]  flags;
    phase_t      false_phase;
    phase_t      true_phase;
    logic        level;
  } hold_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [0] raw_value, [6:1] clear_mask, [7] zero
  logic [1:0]  in_tuser;   // [1:0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;  // [0] filtered_value, [2:1] true_phase, [4:3] false_phase,
                           // [10:5] sticky_flags, [26:11] true_time, [42:27] false_time
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  debounced_hold_time_classifier DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  int unsigned  error_count = 0;
  bit           idle_on = 1'b0;
  hold_result_t pending_results [$];

  // Predictor state; arrays are indexed by level (1 true, 0 false)
  logic        cfg_init;
  logic [15:0] short_thr [2];
  logic [15:0] long_thr [2];
  logic [15:0] stable_thr [2];
  logic        p_level;
  logic [15:0] p_glitch;
  logic [15:0] p_run [2];
  phase_t      p_stage [2];
  logic        p_timing [2];
  logic [5:0]  p_flags;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (error_count < MAX_PRINTED)
      $display("%0t: MISMATCH %s got %h want %h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic logic [15:0] bump_ticks(input logic [15:0] x);
    return (x == 16'hFFFF) ? x : x + 16'd1;
  endfunction

  function automatic void restart_state(input logic lvl);
    p_level     = lvl;
    p_glitch    = '0;
    p_run[0]    = '0;
    p_run[1]    = '0;
    p_timing[0] = 1'b0;
    p_timing[1] = 1'b0;
    p_stage[1]  = lvl ? PH_SHORT : PH_NONE;
    p_stage[0]  = lvl ? PH_NONE : PH_SHORT;
    p_flags     = lvl ? 6'(1 << FLG_WAS) : 6'(1 << (FALSE_GRP + FLG_WAS));
  endfunction

  // Applies one input beat to the predictor and returns the state it reports
  function automatic hold_result_t predict_hold(input logic [1:0] act, input logic raw,
                                                input logic [5:0] mask);
    hold_result_t res;
    logic         lvl;
    logic [2:0]   grp;
    case (act)
      ACT_SAMPLE: begin
        // debounce
        if (raw == p_level) begin
          p_glitch = '0;
        end else begin
          p_glitch = bump_ticks(p_glitch);
          if (p_glitch >= stable_thr[raw]) begin
            p_level  = raw;
            p_glitch = '0;
          end
        end
        lvl = p_level;
        // the other level stops timing
        p_timing[!lvl] = 1'b0;
        p_run[!lvl]    = '0;
        p_stage[!lvl]  = PH_NONE;
        // first held tick counts as 0
        if (p_timing[lvl]) begin
          p_run[lvl] = bump_ticks(p_run[lvl]);
        end else begin
          p_timing[lvl] = 1'b1;
          p_run[lvl]    = '0;
        end
        grp          = '0;
        grp[FLG_WAS] = 1'b1;
        if (p_run[lvl] < short_thr[lvl]) begin
          p_stage[lvl] = PH_SHORT;
        end else if (p_run[lvl] < long_thr[lvl]) begin
          p_stage[lvl] = PH_MID;
          grp[FLG_SHORT] = 1'b1;
        end else begin
          p_stage[lvl] = PH_LONG;
          grp[FLG_LONG] = 1'b1;
        end
        p_flags = p_flags | (lvl ? {3'b000, grp} : {grp, 3'b000});
      end
      ACT_CLEAR:   p_flags = p_flags & ~mask;
      ACT_RESTART: restart_state(cfg_init);
      default: ;
    endcase
    res.level       = p_level;
    res.true_phase  = p_stage[1];
    res.false_phase = p_stage[0];
    res.flags       = p_flags;
    res.true_time   = p_run[1];
    res.false_time  = p_run[0];
    return res;
  endfunction

  // Idle lengths: mostly short, now and then long
  function automatic int unsigned pick_gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // Sends one beat; valid stays high afterwards unless the next beat idles first
  task automatic send_beat(input logic [1:0] act, input logic raw, input logic [5:0] mask);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap_len() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {1'b0, mask, raw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_hold(act, raw, mask));
  endtask

  // Stops sending and waits for every pending result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_INIT_VAL:     cfg_init      = val[0];
      REG_TRUE_SHORT:   short_thr[1]  = val;
      REG_TRUE_LONG:    long_thr[1]   = val;
      REG_FALSE_SHORT:  short_thr[0]  = val;
      REG_FALSE_LONG:   long_thr[0]   = val;
      REG_STABLE_TRUE:  stable_thr[1] = val;
      REG_STABLE_FALSE: stable_thr[0] = val;
      default: ;
    endcase
  endtask

  task automatic send_samples(input logic raw, input int unsigned count);
    repeat (count) send_beat(ACT_SAMPLE, raw, 6'($urandom_range(0, 63)));
  endtask

  // Reset state with all registers at zero: every sample flips at once and is long
  task automatic test_power_up_defaults();
    send_beat(ACT_UNUSED, 1'b1, 6'h3F);
    send_beat(ACT_SAMPLE, 1'b0, 6'h00);
    send_beat(ACT_SAMPLE, 1'b1, 6'h3F);
    send_beat(ACT_SAMPLE, 1'b1, 6'h2A);
    send_beat(ACT_SAMPLE, 1'b0, 6'h15);
    send_beat(ACT_CLEAR, 1'b1, 6'h3F);
    send_beat(ACT_CLEAR, 1'b0, 6'h00);
    send_beat(ACT_RESTART, 1'b1, 6'h3F);
    drain_results();
  endtask

  // Glitches shorter than the stable count, then full runs through all phases
  task automatic test_debounce_and_phases();
    write_reg(REG_TRUE_SHORT, 16'd2);
    write_reg(REG_TRUE_LONG, 16'd4);
    write_reg(REG_FALSE_SHORT, 16'd3);
    write_reg(REG_FALSE_LONG, 16'd6);
    write_reg(REG_STABLE_TRUE, 16'd3);
    write_reg(REG_STABLE_FALSE, 16'd2);
    send_beat(ACT_RESTART, 1'b0, 6'h00);
    send_samples(1'b1, 2);
    send_samples(1'b0, 1);
    send_samples(1'b1, 8);
    send_beat(ACT_CLEAR, 1'b0, 6'h12);
    send_samples(1'b0, 1);
    send_samples(1'b1, 1);
    send_samples(1'b0, 9);
    drain_results();
  endtask

  // Short threshold above long: past short goes straight to long
  task automatic test_inverted_thresholds();
    write_reg(REG_TRUE_SHORT, 16'd5);
    write_reg(REG_TRUE_LONG, 16'd1);
    write_reg(REG_FALSE_SHORT, 16'd4);
    write_reg(REG_FALSE_LONG, 16'd0);
    write_reg(REG_STABLE_TRUE, 16'd0);
    write_reg(REG_STABLE_FALSE, 16'd1);
    send_samples(1'b1, 8);
    send_samples(1'b0, 8);
    drain_results();
  endtask

  // Restart to true, unused register index and action, restart back to false
  task automatic test_restart_high();
    write_reg(REG_INIT_VAL, 16'h0001);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_beat(ACT_RESTART, 1'b0, 6'h3F);
    send_beat(ACT_UNUSED, 1'b0, 6'h00);
    send_samples(1'b1, 3);
    send_beat(ACT_CLEAR, 1'b0, 6'h01);
    send_beat(ACT_RESTART, 1'b1, 6'h00);
    send_samples(1'b0, 3);
    drain_results();
    write_reg(REG_INIT_VAL, 16'hFFFE);
    send_beat(ACT_RESTART, 1'b1, 6'h00);
    send_samples(1'b0, 2);
    drain_results();
  endtask

  // Mostly held levels with glitches, plus clears, restarts and the unused action
  task automatic run_random_items(input int unsigned count);
    logic        lvl;
    int unsigned run_left;
    int unsigned roll;
    lvl      = 1'($urandom_range(0, 1));
    run_left = 0;
    repeat (count) begin
      if (run_left == 0) begin
        lvl      = ~lvl;
        run_left = $urandom_range(1, 20);
      end
      roll = $urandom_range(0, 99);
      if (roll < 78) begin
        send_beat(ACT_SAMPLE, lvl, 6'($urandom_range(0, 63)));
        run_left--;
      end else if (roll < 86) begin
        send_beat(ACT_SAMPLE, ~lvl, 6'($urandom_range(0, 63)));
      end else if (roll < 93) begin
        send_beat(ACT_CLEAR, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
      end else if (roll < 97) begin
        send_beat(ACT_RESTART, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
      end else begin
        send_beat(ACT_UNUSED, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
      end
    end
  endtask

  task automatic test_random_traffic();
    logic [15:0] thr;
    for (int ph = 0; ph < 8; ph++) begin
      idle_on = (ph % 3 != 2);
      write_reg(REG_INIT_VAL, 16'($urandom_range(0, 65535)));
      for (int r = REG_TRUE_SHORT; r <= REG_FALSE_LONG; r++) begin
        thr = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 12));
        write_reg(3'(r), thr);
      end
      write_reg(REG_STABLE_TRUE, 16'($urandom_range(0, 4)));
      write_reg(REG_STABLE_FALSE, 16'($urandom_range(0, 4)));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
      run_random_items(42);
      drain_results();
    end
  endtask

  // Result checker
  always @(posedge clk) begin : check_results
    hold_result_t got;
    hold_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[42:0];
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with none pending", out_tdata[15:0], 16'h0);
      end else begin
        want = pending_results.pop_front();
        if (got.level !== want.level)
          report_mismatch("filtered_value", 16'(got.level), 16'(want.level));
        if (got.true_phase !== want.true_phase)
          report_mismatch("true_phase", 16'(got.true_phase), 16'(want.true_phase));
        if (got.false_phase !== want.false_phase)
          report_mismatch("false_phase", 16'(got.false_phase), 16'(want.false_phase));
        if (got.flags !== want.flags)
          report_mismatch("sticky_flags", 16'(got.flags), 16'(want.flags));
        if (got.true_time !== want.true_time)
          report_mismatch("true_time", got.true_time, want.true_time);
        if (got.false_time !== want.false_time)
          report_mismatch("false_time", got.false_time, want.false_time);
      end
    end
  end

  // Receiver backpressure
  int unsigned ready_hold = 0;
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      ready_hold <= pick_gap_len();
    end else begin
      out_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 6);
    end
  end

  // Watchdog on cycles with no beat moving on either side
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    cfg_init      = 1'b0;
    short_thr[0]  = '0;
    short_thr[1]  = '0;
    long_thr[0]   = '0;
    long_thr[1]   = '0;
    stable_thr[0] = '0;
    stable_thr[1] = '0;
    restart_state(1'b0);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_up_defaults();
    idle_on = 1'b1;
    test_debounce_and_phases();
    test_inverted_thresholds();
    test_restart_high();
    test_random_traffic();

    idle_on = 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
